// ===== src/ipba_pkg.sv =====
package ipba_pkg;

  localparam int POS_W   = 32;
  localparam int RUN_W   = 7;
  localparam int SCORE_W = 16;
  localparam int SIZE_W  = 16;
  localparam int SUM_W   = 32;
  localparam int MEAN_W  = 16;

  localparam int MAX_RUN_DEFAULT = 64;
  localparam logic [SIZE_W-1:0] BIN_SIZE_RESET = 16'd1000;

  typedef struct packed {
    logic load;
    logic step;
  } ipba_cmd_t;

  typedef struct packed {
    logic run_zero;
    logic bin_hit;
    logic walk_done;
    logic walk_ended;
    logic div_busy;
  } ipba_status_t;

endpackage

// ===== src/ipba_div.sv =====
module ipba_div
  import ipba_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic              busy,
  output logic [SUM_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(SUM_W);

  logic [SIZE_W-1:0] rem;
  logic [SIZE_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic [SIZE_W:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem, quotient[SUM_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(SUM_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= SIZE_W'(rem_sh - {1'b0, dvs});
      end else begin
        rem <= rem_sh[SIZE_W-1:0];
      end
      quotient <= {quotient[SUM_W-2:0], fits};
    end
  end

endmodule

// ===== src/ipba_datapath.sv =====
module ipba_datapath
  import ipba_pkg::*;
#(
  parameter int MAX_RUN = MAX_RUN_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  ipba_cmd_t          cmd,
  output ipba_status_t       status,
  input  logic               cfg_we,
  input  logic [SIZE_W-1:0]  cfg_data,
  input  logic [POS_W-1:0]   interval_start,
  input  logic [RUN_W-1:0]   run_length,
  input  logic [SCORE_W-1:0] position_score,
  output logic [POS_W-1:0]   bin_first,
  output logic [POS_W-1:0]   bin_last,
  output logic [MEAN_W-1:0]  bin_mean,
  output logic               last_of_item
);

  logic [SIZE_W-1:0]  bin_size_cfg;
  logic               seeded;
  logic [POS_W-1:0]   current_bin_start;
  logic [SIZE_W-1:0]  counted_positions;
  logic [SUM_W-1:0]   score_total;

  logic [POS_W-1:0]   item_start;
  logic [RUN_W-1:0]   item_run;
  logic [SCORE_W-1:0] item_score;
  logic [RUN_W-1:0]   pos;

  logic [RUN_W-1:0]   run_sat;
  logic [SIZE_W-1:0]  size;
  logic [SUM_W-1:0]   score_total_next;
  logic [SIZE_W-1:0]  counted_next;
  logic [RUN_W-1:0]   pos_next;
  logic [RUN_W-1:0]   left_after;
  logic               hit;
  logic [SUM_W-1:0]   quotient;

  assign run_sat = (run_length > RUN_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : run_length;
  assign size    = (bin_size_cfg == '0) ? SIZE_W'(1) : bin_size_cfg;

  assign score_total_next = score_total + SUM_W'(item_score);
  assign counted_next     = counted_positions + 1'b1;
  assign pos_next         = pos + 1'b1;
  assign left_after       = item_run - pos_next;
  assign hit              = counted_next >= size;

  assign status.run_zero   = run_sat == '0;
  assign status.bin_hit    = hit;
  assign status.walk_done  = pos_next == item_run;
  assign status.walk_ended = pos == item_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_size_cfg      <= BIN_SIZE_RESET;
      seeded            <= 1'b0;
      current_bin_start <= '0;
      counted_positions <= '0;
      score_total       <= '0;
    end else begin
      if (cfg_we) begin
        bin_size_cfg <= cfg_data;
      end
      if (cmd.load && !seeded) begin
        seeded            <= 1'b1;
        current_bin_start <= interval_start;
      end
      if (cmd.step) begin
        if (hit) begin
          current_bin_start <= item_start + POS_W'(pos_next);
          counted_positions <= '0;
          score_total       <= '0;
        end else begin
          counted_positions <= counted_next;
          score_total       <= score_total_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_start <= interval_start;
      item_run   <= run_sat;
      item_score <= position_score;
      pos        <= '0;
    end
    if (cmd.step) begin
      pos <= pos_next;
      if (hit) begin
        bin_first    <= current_bin_start;
        bin_last     <= current_bin_start + POS_W'(size);
        last_of_item <= SIZE_W'(left_after) < size;
      end
    end
  end

  ipba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.step && hit),
    .dividend (score_total_next),
    .divisor  (size),
    .busy     (status.div_busy),
    .quotient (quotient)
  );

  assign bin_mean = quotient[MEAN_W-1:0];

endmodule

// ===== src/ipba_ctrl.sv =====
module ipba_ctrl
  import ipba_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output ipba_cmd_t    cmd,
  input  ipba_status_t status
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!status.run_zero) begin
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if (status.bin_hit) begin
          state_next = S_DIV;
        end else if (status.walk_done) begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (!status.div_busy) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = status.walk_ended ? S_IDLE : S_WALK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/interval_profile_bin_averager_unit.sv =====
// channel  handshake              fields                                        dir
// cfg      cfg_valid cfg_ready    bin_size                                      in
// in       in_valid in_ready      interval_start run_length position_score      in
// out      out_valid out_ready    bin_first bin_last bin_mean last_of_item      out
//
// an item is accepted while idle, then each covered position is walked in turn
// each completed bin waits on the shift-subtract divider and then on the output,
// and the output holds until taken, stalling the walk
// in_ready is high only while no item is being walked
// synchronous reset sets bin_size to 1000 and clears the running bin
module interval_profile_bin_averager_unit
  import ipba_pkg::*;
#(
  parameter int MAX_RUN = MAX_RUN_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SIZE_W-1:0]  bin_size,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [POS_W-1:0]   interval_start,
  input  logic [RUN_W-1:0]   run_length,
  input  logic [SCORE_W-1:0] position_score,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [POS_W-1:0]   bin_first,
  output logic [POS_W-1:0]   bin_last,
  output logic [MEAN_W-1:0]  bin_mean,
  output logic               last_of_item
);

  ipba_cmd_t    cmd;
  ipba_status_t status;

  assign cfg_ready = 1'b1;

  ipba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  ipba_datapath #(
    .MAX_RUN (MAX_RUN)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (bin_size),
    .interval_start (interval_start),
    .run_length     (run_length),
    .position_score (position_score),
    .bin_first      (bin_first),
    .bin_last       (bin_last),
    .bin_mean       (bin_mean),
    .last_of_item   (last_of_item)
  );

endmodule
